FILE: hdl/vigenere_printable_ascii_macros.svh
// Assertion macros for the cipher RTL.
`ifndef VIGENERE_PRINTABLE_ASCII_MACROS_SVH
`define VIGENERE_PRINTABLE_ASCII_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VPA_ASSERT_IMP(LABEL, CLK, RST_N, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |-> (CONS)) \
        else $error(MSG);

// Next-cycle implication, disabled during reset.
`define VPA_ASSERT_NXT(LABEL, CLK, RST_N, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

FILE: hdl/vpa_pkg.sv
// Shared constants and types for the printable ASCII Vigenere cipher.
`default_nettype none

package vpa_pkg;

    localparam int KEY_MAX_BYTES_DEF = 32;
    localparam int KEY_WORDS         = 4;
    localparam int KEY_WORD_W        = 64;
    localparam int KEY_POS_W         = 5;
    localparam int KEY_LEN_W         = 6;
    localparam int SHIFT_W           = 7;
    localparam int CHAR_W            = 8;
    localparam int CFG_IDX_W         = 3;

    localparam logic [CHAR_W-1:0]     PRINT_LOW  = 8'd32;
    localparam logic [CHAR_W-1:0]     PRINT_HIGH = 8'd126;
    localparam logic [CHAR_W-1:0]     NEWLINE    = 8'd10;
    localparam logic [CHAR_W-1:0]     ALPHABET   = 8'd95;
    localparam logic [KEY_WORD_W-1:0] KEY_RESET  = 64'h2020_2020_2020_2020;
    localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RESET = 6'd1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd4;

    typedef struct packed {
        logic emit;
        logic step;
    } vpa_class_t;

endpackage

`default_nettype wire

FILE: hdl/vigenere_printable_ascii.sv
// Top level of the printable ASCII Vigenere cipher stream block.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+--------------------------------------
//  s_axis    | s_axis_tvalid/tready      | tdata: char_in; tuser: func, restart
//  m_axis    | m_axis_tvalid/tready      | tdata: char_out
//  cfg       | cfg_valid/cfg_ready       | cfg_index, cfg_data (64 bits)
//
//  One item per cycle sustained while no held result stalls the input register.
//  The input register feeds classification, key byte select and the modulo 95
//  add or subtract, which load the result register.
//  Reset clears both valid flags and the key position, and loads an all-space key.
//  A held result stalls the input register only for items that produce one.
//  Configuration writes are never stalled; cfg_ready is always high.
`default_nettype none

module vigenere_printable_ascii #(
    parameter int KEY_MAX_BYTES = vpa_pkg::KEY_MAX_BYTES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // [7:0] char_in
    input  wire logic [1:0]                     s_axis_tuser,  // [0] func, [1] restart
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [7:0]                     m_axis_tdata,  // [7:0] char_out
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [vpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vpa_pkg::KEY_WORD_W-1:0] cfg_data
);
    import vpa_pkg::*;

    `include "vigenere_printable_ascii_macros.svh"

    logic                 in_valid_reg;
    logic                 in_func_reg;
    logic                 in_restart_reg;
    logic [CHAR_W-1:0]    in_char_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg;
    logic [KEY_POS_W-1:0] pos_reg;
    logic [KEY_POS_W-1:0] pos_next;

    logic                 in_take;
    logic                 stage_go;
    logic [KEY_POS_W-1:0] pos_cur;
    logic [KEY_LEN_W-1:0] pos_inc;
    logic [SHIFT_W-1:0]   key_shift;
    logic [KEY_LEN_W-1:0] key_len;
    logic [CHAR_W-1:0]    char_res;
    vpa_class_t           cls;

    vpa_key_store #(
        .KEY_MAX_BYTES (KEY_MAX_BYTES)
    ) u_key_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_pos   (pos_cur),
        .key_shift (key_shift),
        .key_len   (key_len)
    );

    vpa_cipher u_cipher (
        .func      (in_func_reg),
        .char_in   (in_char_reg),
        .key_shift (key_shift),
        .char_out  (char_res),
        .cls       (cls)
    );

    assign cfg_ready     = 1'b1;
    assign stage_go      = in_valid_reg && (!cls.emit || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || stage_go;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;

    always_comb
    begin
        pos_cur = in_restart_reg ? '0 : pos_reg;
        pos_inc = {1'b0, pos_cur} + KEY_LEN_W'(1);
        if (!cls.step)
        begin
            pos_next = pos_cur;
        end
        else if (pos_inc >= key_len)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_inc[KEY_POS_W-1:0];
        end
        out_valid_next = (out_valid_reg && !m_axis_tready) || (stage_go && cls.emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (stage_go)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
            if (stage_go)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_func_reg    <= s_axis_tuser[0];
            in_restart_reg <= s_axis_tuser[1];
            in_char_reg    <= s_axis_tdata;
        end
        if (stage_go && cls.emit)
        begin
            out_char_reg <= char_res;
        end
    end

    `VPA_ASSERT_NXT(a_pos_in_len, clk, rst_n, stage_go && cls.step,
        {1'b0, pos_reg} < $past(key_len), "key position beyond key length")
    `VPA_ASSERT_NXT(a_restart_nl, clk, rst_n, stage_go && in_restart_reg && !cls.step,
        pos_reg == '0, "restart on newline did not clear key position")
    `VPA_ASSERT_IMP(a_out_class, clk, rst_n, m_axis_tvalid,
        (m_axis_tdata >= PRINT_LOW && m_axis_tdata <= PRINT_HIGH) || m_axis_tdata == NEWLINE,
        "result is neither printable nor newline")
    `VPA_ASSERT_IMP(a_no_overrun, clk, rst_n, out_valid_reg && !m_axis_tready && cls.emit,
        !stage_go, "held result overwritten")

endmodule

`default_nettype wire

FILE: hdl/vpa_key_store.sv
// Key registers, key length clamp and key byte selection.
`default_nettype none

module vpa_key_store #(
    parameter int KEY_MAX_BYTES = vpa_pkg::KEY_MAX_BYTES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [vpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vpa_pkg::KEY_WORD_W-1:0] cfg_data,
    input  wire logic [vpa_pkg::KEY_POS_W-1:0]  key_pos,
    output logic      [vpa_pkg::SHIFT_W-1:0]    key_shift,
    output logic      [vpa_pkg::KEY_LEN_W-1:0]  key_len
);
    import vpa_pkg::*;

    logic [KEY_WORD_W-1:0]            key_word_reg [KEY_WORDS];
    logic [KEY_LEN_W-1:0]             key_length_reg;
    logic [KEY_WORDS*KEY_WORD_W-1:0]  key_vec;
    logic [CHAR_W-1:0]                key_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_word_reg[i] <= KEY_RESET;
            end
            key_length_reg <= KEY_LEN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_WORD_0: key_word_reg[0] <= cfg_data;
                REG_KEY_WORD_1: key_word_reg[1] <= cfg_data;
                REG_KEY_WORD_2: key_word_reg[2] <= cfg_data;
                REG_KEY_WORD_3: key_word_reg[3] <= cfg_data;
                REG_KEY_LENGTH: key_length_reg <= cfg_data[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            key_vec[i*KEY_WORD_W +: KEY_WORD_W] = key_word_reg[i];
        end
        key_byte = key_vec[key_pos*CHAR_W +: CHAR_W];
        if (key_byte inside {[PRINT_LOW:PRINT_HIGH]})
        begin
            key_shift = SHIFT_W'(key_byte - PRINT_LOW);
        end
        else
        begin
            key_shift = '0;
        end

        if (key_length_reg == '0)
        begin
            key_len = KEY_LEN_W'(1);
        end
        else if (key_length_reg > KEY_LEN_W'(KEY_MAX_BYTES))
        begin
            key_len = KEY_LEN_W'(KEY_MAX_BYTES);
        end
        else
        begin
            key_len = key_length_reg;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/vpa_cipher.sv
// Byte classification and modulo 95 shift of one character.
`default_nettype none

module vpa_cipher (
    input  wire logic                        func,
    input  wire logic [vpa_pkg::CHAR_W-1:0]  char_in,
    input  wire logic [vpa_pkg::SHIFT_W-1:0] key_shift,
    output logic      [vpa_pkg::CHAR_W-1:0]  char_out,
    output vpa_pkg::vpa_class_t              cls
);
    import vpa_pkg::*;

    logic              is_newline;
    logic              is_print;
    logic [CHAR_W-1:0] x;
    logic [CHAR_W-1:0] y;
    logic [CHAR_W-1:0] raw;
    logic [CHAR_W-1:0] r;

    always_comb
    begin
        is_newline = (char_in == NEWLINE);
        is_print   = char_in inside {[PRINT_LOW:PRINT_HIGH]};
        cls.emit   = is_newline || is_print;
        cls.step   = !is_newline;

        x = char_in - PRINT_LOW;
        y = {1'b0, key_shift};
        if (func)
        begin
            raw = x + ALPHABET - y;
        end
        else
        begin
            raw = x + y;
        end
        if (raw >= ALPHABET)
        begin
            r = raw - ALPHABET;
        end
        else
        begin
            r = raw;
        end

        if (is_newline)
        begin
            char_out = NEWLINE;
        end
        else
        begin
            char_out = r + PRINT_LOW;
        end
    end

endmodule

`default_nettype wire

FILE: test/vigenere_printable_ascii_tb.sv
// Testbench for the printable ASCII Vigenere cipher stream block with a self-checking predictor.
`default_nettype none

module vigenere_printable_ascii_tb;

    import vpa_pkg::*;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   RANDOM_PHASES = 10;
    localparam int   PHASE_BYTES = 165;

    typedef struct {
        logic        op;
        logic        restart;
        logic [7:0]  ch;
        int unsigned gap;
    } byte_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // [7:0] char_in
    logic [1:0]            s_axis_tuser = '0;   // [0] func, [1] restart
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;        // [7:0] char_out
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [KEY_WORD_W-1:0] cfg_data = '0;

    byte_item_t       tx_bytes[$];
    logic [7:0]       cipher_due[$];
    logic [63:0]      key_words[4];
    logic [5:0]       key_len;
    logic [4:0]       key_pos;
    int unsigned      tx_waited = 0;
    int unsigned      tx_idle_max = 12;
    int unsigned      rx_idle_max = 12;
    int unsigned      rx_wait = 0;
    logic             rx_hold_off = 1'b0;
    int               items_accepted = 0;
    int               errors = 0;

    vigenere_printable_ascii u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void advance_key();
        logic [5:0] len;
        logic [5:0] nxt;
        len = key_len;
        if (len == 6'd0)
            len = 6'd1;
        if (len > 6'(KEY_MAX_BYTES_DEF))
            len = 6'(KEY_MAX_BYTES_DEF);
        nxt = {1'b0, key_pos} + 6'd1;
        key_pos = (nxt >= len) ? 5'd0 : nxt[4:0];
    endfunction

    function automatic logic cipher_step(input logic op, input logic restart,
                                         input logic [7:0] ch, output logic [7:0] res);
        logic [7:0] kbyte;
        logic [6:0] shift;
        logic [7:0] sum;
        res = '0;
        if (restart)
            key_pos = '0;
        if (ch == NEWLINE)
        begin
            res = NEWLINE;
            return 1'b1;
        end
        if (ch < PRINT_LOW || ch > PRINT_HIGH)
        begin
            advance_key();
            return 1'b0;
        end
        kbyte = key_words[key_pos[4:3]][key_pos[2:0]*8 +: 8];
        shift = (kbyte < PRINT_LOW || kbyte > PRINT_HIGH) ? 7'd0 : 7'(kbyte - PRINT_LOW);
        if (op == OP_ENCODE)
            sum = (ch - PRINT_LOW) + shift;
        else
            sum = (ch - PRINT_LOW) + (ALPHABET - shift);
        if (sum >= ALPHABET)
            sum = sum - ALPHABET;
        res = sum + PRINT_LOW;
        advance_key();
        return 1'b1;
    endfunction

    // driver
    always @(posedge clk)
    begin
        logic       has_out;
        logic [7:0] out_char;
        byte_item_t nxt_item;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            tx_waited <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                items_accepted <= items_accepted + 1;
                has_out = cipher_step(s_axis_tuser[0], s_axis_tuser[1], s_axis_tdata, out_char);
                if (has_out)
                    cipher_due.push_back(out_char);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_bytes.size() == 0)
                    s_axis_tvalid <= 1'b0;
                else if (tx_waited < tx_bytes[0].gap)
                begin
                    tx_waited <= tx_waited + 1;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    nxt_item = tx_bytes.pop_front();
                    s_axis_tdata <= nxt_item.ch;
                    s_axis_tuser <= {nxt_item.restart, nxt_item.op};
                    s_axis_tvalid <= 1'b1;
                    tx_waited <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        logic [7:0]  want;
        int unsigned n;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_wait <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (cipher_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected item: char_out %h", m_axis_tdata);
                end
                else
                begin
                    want = cipher_due.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("char_out mismatch: expected %h, actual %h",
                                     want, m_axis_tdata);
                    end
                end
            end
            if (rx_hold_off)
                m_axis_tready <= 1'b0;
            else if (rx_wait != 0)
            begin
                rx_wait <= rx_wait - 1;
                m_axis_tready <= 1'b0;
            end
            else if (m_axis_tvalid && m_axis_tready && rx_idle_max != 0)
            begin
                n = $urandom_range(0, rx_idle_max);
                if (n == 0)
                    m_axis_tready <= 1'b1;
                else
                begin
                    m_axis_tready <= 1'b0;
                    rx_wait <= n - 1;
                end
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : rx_pressure
        while (items_accepted < 600)
            @(posedge clk);
        rx_hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold_off <= 1'b0;
    end

    initial
    begin : watchdog
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_KEY_WORD_0: key_words[0] = value;
            REG_KEY_WORD_1: key_words[1] = value;
            REG_KEY_WORD_2: key_words[2] = value;
            REG_KEY_WORD_3: key_words[3] = value;
            REG_KEY_LENGTH: key_len = value[5:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_byte(input logic op, input logic restart, input logic [7:0] ch);
        byte_item_t item;
        item.op = op;
        item.restart = restart;
        item.ch = ch;
        item.gap = (tx_idle_max == 0) ? 0 : $urandom_range(0, tx_idle_max);
        tx_bytes.push_back(item);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (tx_bytes.size() != 0 || s_axis_tvalid || cipher_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [63:0] word;
        logic [7:0]  ch;
        int          sel;
        for (int i = 0; i < 4; i++)
            key_words[i] = KEY_RESET;
        key_len = KEY_LEN_RESET;
        key_pos = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset key: every shift is zero
        queue_byte(OP_ENCODE, 1'b0, PRINT_LOW);
        queue_byte(OP_DECODE, 1'b0, PRINT_HIGH);
        queue_byte(OP_ENCODE, 1'b1, NEWLINE);
        queue_byte(OP_DECODE, 1'b0, 8'h00);
        wait_drained();

        // key with extreme and out-of-range bytes
        write_reg(REG_KEY_WORD_0, 64'h217F_1FFF_0020_7E41);
        write_reg(REG_KEY_LENGTH, 64'd8);
        @(negedge clk);
        queue_byte(OP_ENCODE, 1'b1, PRINT_HIGH);
        queue_byte(OP_ENCODE, 1'b0, PRINT_HIGH);
        queue_byte(OP_DECODE, 1'b0, PRINT_LOW);
        queue_byte(OP_DECODE, 1'b1, NEWLINE);
        queue_byte(OP_DECODE, 1'b0, PRINT_LOW);
        queue_byte(OP_ENCODE, 1'b0, 8'h00);
        queue_byte(OP_DECODE, 1'b0, 8'hFF);
        queue_byte(OP_ENCODE, 1'b0, 8'h1F);
        queue_byte(OP_ENCODE, 1'b0, 8'h7F);
        queue_byte(OP_DECODE, 1'b0, PRINT_HIGH);
        queue_byte(OP_ENCODE, 1'b0, 8'h41);
        queue_byte(OP_DECODE, 1'b0, PRINT_HIGH);
        queue_byte(OP_ENCODE, 1'b0, NEWLINE);
        wait_drained();

        // full length key, then shorten it below the current position
        write_reg(REG_KEY_WORD_1, 64'h7E7D_5A41_3130_2221);
        write_reg(REG_KEY_WORD_2, 64'h6F6E_6D6C_4B4A_4948);
        write_reg(REG_KEY_WORD_3, 64'h7E20_7E20_5F5E_5D5C);
        write_reg(REG_KEY_LENGTH, 64'd32);
        @(negedge clk);
        queue_byte(OP_ENCODE, 1'b1, 8'h61);
        for (int i = 0; i < 5; i++)
            queue_byte(OP_DECODE, 1'b0, 8'h7A);
        wait_drained();
        write_reg(REG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFC3);
        @(negedge clk);
        queue_byte(OP_ENCODE, 1'b0, 8'h50);
        queue_byte(OP_ENCODE, 1'b0, 8'h50);
        queue_byte(OP_DECODE, 1'b0, 8'h50);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sel = $urandom_range(0, 9);
                case (sel)
                    0: word = '0;
                    1: word = '1;
                    2: word = {$urandom, $urandom};
                    default:
                        for (int b = 0; b < 8; b++)
                            word[b*8 +: 8] = 8'($urandom_range(32, 126));
                endcase
                write_reg(CFG_IDX_W'(k), word);
            end
            word = {$urandom, $urandom};
            sel = $urandom_range(0, 6);
            case (sel)
                0: word[5:0] = 6'd0;
                1: word[5:0] = 6'd1;
                2: word[5:0] = 6'd32;
                3: word[5:0] = 6'd63;
                default: word[5:0] = 6'($urandom_range(1, 32));
            endcase
            write_reg(REG_KEY_LENGTH, word);
            @(posedge clk);
            rx_idle_max <= (ph % 3 == 2) ? 0 : 12;
            @(negedge clk);
            tx_idle_max = (ph % 3 == 2) ? 0 : 12;
            for (int i = 0; i < PHASE_BYTES; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    ch = 8'($urandom_range(32, 126));
                else if (sel < 80)
                    ch = NEWLINE;
                else if (sel < 90)
                    ch = 8'($urandom_range(0, 31));
                else
                    ch = 8'($urandom_range(127, 255));
                queue_byte(1'($urandom_range(0, 1)), ($urandom_range(0, 15) == 0), ch);
            end
            wait_drained();
        end

        if (errors == 0 && cipher_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/vpa_pkg.sv
hdl/vpa_key_store.sv
hdl/vpa_cipher.sv
hdl/vigenere_printable_ascii.sv
test/vigenere_printable_ascii_tb.sv
